### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the heap datapath.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define IMH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("heap assertion failed");

// A condition that must never be true outside reset.
`define IMH_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("heap forbidden condition seen");

`endif

### rtl/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg
// Types and constants of the indexed min-heap.
// ----------------------------------------------------------------------------
package imh_pkg;

    localparam int CAPACITY = 1024;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = SLOT_W + 1;
    localparam int VTX_W    = 10;
    localparam int COST_W   = 32;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_UPDATE  = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    take;
        logic    ins_start;
        logic    ex_start;
        logic    ud_start;
        logic    clr_start;
        logic    clr_step;
        logic    up_read;
        logic    up_move;
        logic    ex_root;
        logic    ex_last;
        logic    dn_left;
        logic    dn_right_eval;
        logic    dn_cmp;
        logic    dn_move;
        logic    ud_found;
        logic    ud_vertex;
        logic    fin;
        logic    res_load;
        status_t res_status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic full;
        logic empty;
        logic one_left;
        logic i_zero;
        logic up_less;
        logic left_ok;
        logic right_ok;
        logic has_best;
        logic ud_ok;
        logic clr_done;
    } stat_t;

endpackage

### rtl/imh_ctrl.sv
// ----------------------------------------------------------------------------
// imh_ctrl
// Sequencer for insert, extract, update and clear, one item at a time.
// ----------------------------------------------------------------------------
module imh_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  imh_pkg::op_t    in_op,
    input  imh_pkg::stat_t  sts,
    output imh_pkg::cmd_t   cmd
);
    import imh_pkg::*;

    typedef enum logic [12:0] {
        S_CLR     = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_UP_RD   = 13'b0000000000100,
        S_UP_CMP  = 13'b0000000001000,
        S_EX_ROOT = 13'b0000000010000,
        S_EX_LAST = 13'b0000000100000,
        S_DN_RDL  = 13'b0000001000000,
        S_DN_RDR  = 13'b0000010000000,
        S_DN_CMP  = 13'b0000100000000,
        S_DN_MOV  = 13'b0001000000000,
        S_UD_CHK  = 13'b0010000000000,
        S_UD_VX   = 13'b0100000000000,
        S_FIN     = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   resp_reg, resp_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        resp_next  = resp_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    // The pass after reset gives no result; a clear item does.
                    if (resp_reg)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_OK;
                    end
                    resp_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = !sts.out_free;
                if (in_valid && sts.out_free)
                begin
                    cmd.take = 1'b1;
                    unique case (in_op)
                        OP_INSERT:
                        begin
                            if (sts.full)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.ins_start = 1'b1;
                                state_next    = S_UP_RD;
                            end
                        end
                        OP_EXTRACT:
                        begin
                            if (sts.empty)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.ex_start = 1'b1;
                                state_next   = S_EX_ROOT;
                            end
                        end
                        OP_UPDATE:
                        begin
                            cmd.ud_start = 1'b1;
                            state_next   = S_UD_CHK;
                        end
                        OP_CLEAR:
                        begin
                            cmd.clr_start = 1'b1;
                            resp_next     = 1'b1;
                            state_next    = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                if (sts.i_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.up_read = 1'b1;
                    state_next  = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (sts.up_less)
                begin
                    cmd.up_move = 1'b1;
                    state_next  = S_UP_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_EX_ROOT:
            begin
                cmd.ex_root = 1'b1;
                if (sts.one_left)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_EX_LAST;
                end
            end
            S_EX_LAST:
            begin
                cmd.ex_last = 1'b1;
                state_next  = S_DN_RDL;
            end
            S_DN_RDL:
            begin
                if (sts.left_ok)
                begin
                    cmd.dn_left = 1'b1;
                    state_next  = S_DN_RDR;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DN_RDR:
            begin
                cmd.dn_right_eval = 1'b1;
                state_next        = sts.right_ok ? S_DN_CMP : S_DN_MOV;
            end
            S_DN_CMP:
            begin
                cmd.dn_cmp = 1'b1;
                state_next = S_DN_MOV;
            end
            S_DN_MOV:
            begin
                if (sts.has_best)
                begin
                    cmd.dn_move = 1'b1;
                    state_next  = S_DN_RDL;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_UD_CHK:
            begin
                if (sts.ud_ok)
                begin
                    cmd.ud_found = 1'b1;
                    state_next   = S_UD_VX;
                end
                else
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_ABSENT;
                    state_next     = S_IDLE;
                end
            end
            S_UD_VX:
            begin
                cmd.ud_vertex = 1'b1;
                state_next    = S_UP_RD;
            end
            S_FIN:
            begin
                cmd.fin        = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            resp_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

endmodule

### rtl/imh_dp.sv
// ----------------------------------------------------------------------------
// imh_dp
// Heap slot memory, position table, presence bits, sift registers and the
// result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imh_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [imh_pkg::VTX_W-1:0]            vertex,
    input  logic signed [imh_pkg::COST_W-1:0]    cost,
    input  logic                                 out_stall,
    input  imh_pkg::cmd_t                        cmd,
    output imh_pkg::stat_t                       sts,
    output logic                                 out_valid,
    output logic [1:0]                           status,
    output logic [imh_pkg::VTX_W-1:0]            out_vertex,
    output logic signed [imh_pkg::COST_W-1:0]    out_cost,
    output logic [imh_pkg::CNT_W-1:0]            count
);
    import imh_pkg::*;

    typedef struct packed {
        logic [VTX_W-1:0]         v;
        logic signed [COST_W-1:0] c;
    } ent_t;

    // Memories.
    ent_t              hs_mem [CAPACITY];
    logic [SLOT_W-1:0] vs_mem [CAPACITY];
    logic              pr_mem [CAPACITY];

    ent_t              hs_rd;
    logic [SLOT_W-1:0] vs_rd;
    logic              pr_rd;

    logic              hs_re, hs_we, vs_we, pr_we, tab_re;
    logic [SLOT_W-1:0] hs_raddr, hs_waddr, vs_wdata;
    logic [VTX_W-1:0]  vs_waddr, pr_waddr;
    ent_t              hs_wdata;
    logic              pr_wdata;

    // Control and working registers.
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [SLOT_W-1:0]        clr_idx_reg;
    logic                     out_valid_reg;
    logic [SLOT_W-1:0]        i_reg, i_next;
    ent_t                     cur_reg, cur_next;
    logic signed [COST_W-1:0] op_c_reg;
    logic [VTX_W-1:0]         last_v_reg;
    logic                     swapped_reg, winit_reg, has_reg;
    ent_t                     best_reg;
    logic [SLOT_W-1:0]        best_idx_reg;
    ent_t                     ex_reg, ex_next;
    status_t                  status_reg;
    logic [VTX_W-1:0]         out_v_reg;
    logic signed [COST_W-1:0] out_c_reg;
    logic [CNT_W-1:0]         out_n_reg;

    logic [SLOT_W-1:0]        parent;
    logic [SLOT_W-1:0]        last_slot;
    logic [CNT_W:0]           left_w, right_w;
    logic                     left_ok, right_ok, out_free, vs_fin_en;
    logic signed [COST_W-1:0] best_c_eff;

    assign parent     = (i_reg - 1'b1) >> 1;
    assign last_slot  = SLOT_W'(count_reg - 1'b1);
    assign left_w     = {1'b0, i_reg, 1'b1};
    assign right_w    = left_w + 1'b1;
    assign left_ok    = left_w < {1'b0, count_reg};
    assign right_ok   = right_w < {1'b0, count_reg};
    assign out_free   = !out_valid_reg || !out_stall;
    assign best_c_eff = has_reg ? best_reg.c : cur_reg.c;
    // The moving entry's position is written at the end unless an update never
    // moved it or the last entry passed has the same vertex and keeps its slot.
    assign vs_fin_en  = swapped_reg ? (last_v_reg != cur_reg.v) : winit_reg;

    always_comb
    begin
        sts.out_free = out_free;
        sts.full     = count_reg == CNT_W'(CAPACITY);
        sts.empty    = count_reg == '0;
        sts.one_left = count_reg == CNT_W'(1);
        sts.i_zero   = i_reg == '0;
        sts.up_less  = cur_reg.c < hs_rd.c;
        sts.left_ok  = left_ok;
        sts.right_ok = right_ok;
        sts.has_best = has_reg;
        sts.ud_ok    = pr_rd && ({1'b0, vs_rd} < count_reg);
        sts.clr_done = clr_idx_reg == SLOT_W'(CAPACITY - 1);
    end

    // Memory port selection.
    always_comb
    begin
        hs_re    = 1'b0;
        hs_raddr = '0;
        if (cmd.ex_root)
        begin
            hs_re    = 1'b1;
            hs_raddr = last_slot;
        end
        else if (cmd.up_read)
        begin
            hs_re    = 1'b1;
            hs_raddr = parent;
        end
        else if (cmd.dn_left)
        begin
            hs_re    = 1'b1;
            hs_raddr = left_w[SLOT_W-1:0];
        end
        else if (cmd.dn_right_eval)
        begin
            hs_re    = right_ok;
            hs_raddr = right_w[SLOT_W-1:0];
        end
        else if (cmd.ud_found)
        begin
            hs_re    = 1'b1;
            hs_raddr = vs_rd;
        end
        else if (cmd.ex_start)
        begin
            hs_re    = 1'b1;
            hs_raddr = '0;
        end

        hs_we    = 1'b0;
        hs_waddr = i_reg;
        hs_wdata = cur_reg;
        vs_we    = 1'b0;
        vs_waddr = cur_reg.v;
        vs_wdata = i_reg;
        if (cmd.up_move)
        begin
            hs_we    = 1'b1;
            hs_wdata = hs_rd;
            vs_we    = 1'b1;
            vs_waddr = hs_rd.v;
        end
        else if (cmd.dn_move)
        begin
            hs_we    = 1'b1;
            hs_wdata = best_reg;
            vs_we    = 1'b1;
            vs_waddr = best_reg.v;
        end
        else if (cmd.fin)
        begin
            hs_we = 1'b1;
            vs_we = vs_fin_en;
        end

        pr_we    = 1'b0;
        pr_waddr = vertex;
        pr_wdata = 1'b0;
        if (cmd.ins_start)
        begin
            pr_we    = 1'b1;
            pr_wdata = 1'b1;
        end
        else if (cmd.ex_root)
        begin
            pr_we    = 1'b1;
            pr_waddr = hs_rd.v;
        end
        else if (cmd.ex_last)
        begin
            pr_we    = 1'b1;
            pr_waddr = hs_rd.v;
            pr_wdata = 1'b1;
        end
        else if (cmd.clr_step)
        begin
            pr_we    = 1'b1;
            pr_waddr = clr_idx_reg;
        end

        tab_re = cmd.ud_start;
    end

    always_ff @(posedge clk)
    begin
        if (hs_we)
        begin
            hs_mem[hs_waddr] <= hs_wdata;
        end
        if (hs_re)
        begin
            hs_rd <= hs_mem[hs_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vs_we)
        begin
            vs_mem[vs_waddr] <= vs_wdata;
        end
        if (tab_re)
        begin
            vs_rd <= vs_mem[vertex];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pr_we)
        begin
            pr_mem[pr_waddr] <= pr_wdata;
        end
        if (tab_re)
        begin
            pr_rd <= pr_mem[vertex];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr_start)
        begin
            count_next = '0;
        end
        else if (cmd.ins_start)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.ex_root)
        begin
            count_next = count_reg - 1'b1;
        end

        ex_next = ex_reg;
        if (cmd.take)
        begin
            ex_next = '0;
        end
        else if (cmd.ex_root)
        begin
            ex_next = hs_rd;
        end

        i_next   = i_reg;
        cur_next = cur_reg;
        if (cmd.ins_start)
        begin
            i_next   = count_reg[SLOT_W-1:0];
            cur_next = '{v: vertex, c: cost};
        end
        else if (cmd.up_move)
        begin
            i_next = parent;
        end
        else if (cmd.ex_last)
        begin
            i_next   = '0;
            cur_next = hs_rd;
        end
        else if (cmd.dn_move)
        begin
            i_next = best_idx_reg;
        end
        else if (cmd.ud_found)
        begin
            i_next = vs_rd;
        end
        else if (cmd.ud_vertex)
        begin
            cur_next = '{v: hs_rd.v, c: op_c_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.clr_start)
            begin
                clr_idx_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        cur_reg <= cur_next;
        ex_reg  <= ex_next;
        if (cmd.ud_start)
        begin
            op_c_reg <= cost;
        end
        if (cmd.ins_start || cmd.ex_last)
        begin
            swapped_reg <= 1'b0;
            winit_reg   <= 1'b1;
        end
        else if (cmd.ud_vertex)
        begin
            swapped_reg <= 1'b0;
            winit_reg   <= 1'b0;
        end
        else if (cmd.up_move)
        begin
            swapped_reg <= 1'b1;
            last_v_reg  <= hs_rd.v;
        end
        else if (cmd.dn_move)
        begin
            swapped_reg <= 1'b1;
            last_v_reg  <= best_reg.v;
        end
        if (cmd.dn_right_eval)
        begin
            has_reg <= hs_rd.c < cur_reg.c;
            if (hs_rd.c < cur_reg.c)
            begin
                best_reg     <= hs_rd;
                best_idx_reg <= left_w[SLOT_W-1:0];
            end
        end
        else if (cmd.dn_cmp && (hs_rd.c < best_c_eff))
        begin
            has_reg      <= 1'b1;
            best_reg     <= hs_rd;
            best_idx_reg <= right_w[SLOT_W-1:0];
        end
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            out_v_reg  <= ex_next.v;
            out_c_reg  <= ex_next.c;
            out_n_reg  <= count_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign out_vertex = out_v_reg;
    assign out_cost   = out_c_reg;
    assign count      = out_n_reg;

    `IMH_ASSERT(a_count_le_cap, clk, rst_n, (count_reg <= CNT_W'(CAPACITY)))
    `IMH_ASSERT(a_fin_in_heap, clk, rst_n, (cmd.fin |-> ({1'b0, i_reg} < count_reg)))
    `IMH_NEVER(a_res_overwrite, clk, rst_n, (cmd.res_load && !out_free))

endmodule

### rtl/indexed_min_heap.sv
// ----------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap of (vertex, cost) pairs with a vertex position
// table: insert, extract-min, decrease-key update and clear.
// ----------------------------------------------------------------------------
//  channel | handshake            | fields
//  --------+----------------------+-----------------------------------------
//  input   | in_valid / in_stall  | op, vertex, cost
//  output  | out_valid / out_stall| status, out_vertex, out_cost, count
//
// One item at a time. An insert sifts the new entry up level by level, an
// update looks up the vertex's slot and then sifts up the same way, and an
// extract moves the last entry to the root and sifts it down; full and empty
// answers, an absent update and an extract of the last entry skip the sifting.
// After reset and on every clear item, a pass clears all the presence bits.
// A result waits in the output register; a stalled output holds the next item.
// ----------------------------------------------------------------------------
module indexed_min_heap
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           op,
    input  logic [imh_pkg::VTX_W-1:0]            vertex,
    input  logic signed [imh_pkg::COST_W-1:0]    cost,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           status,
    output logic [imh_pkg::VTX_W-1:0]            out_vertex,
    output logic signed [imh_pkg::COST_W-1:0]    out_cost,
    output logic [imh_pkg::CNT_W-1:0]            count
);
    import imh_pkg::*;

    cmd_t  cmd;
    stat_t sts;

    imh_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_op    (op_t'(op)),
        .sts      (sts),
        .cmd      (cmd)
    );

    imh_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .vertex     (vertex),
        .cost       (cost),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .status     (status),
        .out_vertex (out_vertex),
        .out_cost   (out_cost),
        .count      (count)
    );

endmodule

### dv/tb_indexed_min_heap.sv
// ----------------------------------------------------------------------------
// tb_indexed_min_heap
// Self-checking bench for the indexed min-heap. A behavioral heap with its
// own position table predicts each result. Directed tests cover the corner
// cases, and random sequences of inserts, extracts, updates and clears run
// with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap;
    import imh_pkg::*;

    typedef struct packed {
        status_t                   st;
        logic [VTX_W-1:0]          vtx;
        logic signed [COST_W-1:0]  cst;
        logic [CNT_W-1:0]          cnt;
    } heap_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [1:0]                 op;
    logic [VTX_W-1:0]           vertex;
    logic signed [COST_W-1:0]   cost;
    logic                       out_valid;
    logic                       out_stall;
    logic [1:0]                 status;
    logic [VTX_W-1:0]           out_vertex;
    logic signed [COST_W-1:0]   out_cost;
    logic [CNT_W-1:0]           count;

    indexed_min_heap i_dut
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .vertex(vertex), .cost(cost), .out_valid(out_valid),
        .out_stall(out_stall), .status(status), .out_vertex(out_vertex),
        .out_cost(out_cost), .count(count)
    );

    // Behavioral heap state.
    logic [VTX_W-1:0]           heap_vtx [CAPACITY];
    logic signed [COST_W-1:0]   heap_cost [CAPACITY];
    int unsigned                pos_of [CAPACITY];
    bit                         on_heap [CAPACITY];
    int unsigned                heap_size;

    heap_result_t               pending_results [$];
    bit                         failed;
    longint unsigned            cycle_cnt;
    bit                         hot_vertex;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > 3000000)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic void swap_entries(int unsigned a, int unsigned b);
        logic [VTX_W-1:0]         tv;
        logic signed [COST_W-1:0] tc;
        tv = heap_vtx[a];
        tc = heap_cost[a];
        pos_of[heap_vtx[a]] = b;
        pos_of[heap_vtx[b]] = a;
        heap_vtx[a] = heap_vtx[b];
        heap_cost[a] = heap_cost[b];
        heap_vtx[b] = tv;
        heap_cost[b] = tc;
    endfunction

    function automatic void bubble_up(int unsigned i);
        int unsigned p;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!(heap_cost[i] < heap_cost[p]))
                break;
            swap_entries(i, p);
            i = p;
        end
    endfunction

    function automatic void bubble_down(int unsigned i);
        int unsigned best;
        int unsigned l;
        int unsigned r;
        forever
        begin
            best = i;
            l = 2 * i + 1;
            r = 2 * i + 2;
            if (l < heap_size && heap_cost[l] < heap_cost[best])
                best = l;
            if (r < heap_size && heap_cost[r] < heap_cost[best])
                best = r;
            if (best == i)
                break;
            swap_entries(i, best);
            i = best;
        end
    endfunction

    function automatic heap_result_t apply_heap_op(op_t o, logic [VTX_W-1:0] v,
                                                   logic signed [COST_W-1:0] c);
        heap_result_t r;
        int unsigned  last;
        int unsigned  s;
        r = '0;
        r.st = ST_OK;
        case (o)
            OP_INSERT:
            begin
                if (heap_size >= CAPACITY)
                    r.st = ST_FULL;
                else
                begin
                    s = heap_size;
                    heap_vtx[s] = v;
                    heap_cost[s] = c;
                    pos_of[v] = s;
                    on_heap[v] = 1'b1;
                    heap_size = s + 1;
                    bubble_up(s);
                end
            end
            OP_EXTRACT:
            begin
                if (heap_size == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    last = heap_size - 1;
                    r.vtx = heap_vtx[0];
                    r.cst = heap_cost[0];
                    on_heap[heap_vtx[0]] = 1'b0;
                    heap_size = last;
                    if (last > 0)
                    begin
                        heap_vtx[0] = heap_vtx[last];
                        heap_cost[0] = heap_cost[last];
                        pos_of[heap_vtx[0]] = 0;
                        on_heap[heap_vtx[0]] = 1'b1;
                        bubble_down(0);
                    end
                end
            end
            OP_UPDATE:
            begin
                if (!on_heap[v] || pos_of[v] >= heap_size)
                    r.st = ST_ABSENT;
                else
                begin
                    heap_cost[pos_of[v]] = c;
                    bubble_up(pos_of[v]);
                end
            end
            default:
            begin
                heap_size = 0;
                foreach (on_heap[k])
                    on_heap[k] = 1'b0;
            end
        endcase
        r.cnt = CNT_W'(heap_size);
        return r;
    endfunction

    task automatic send_item(op_t o, logic [VTX_W-1:0] v, logic signed [COST_W-1:0] c);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        vertex <= v;
        cost <= c;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(apply_heap_op(o, v, c));
    endtask

    // Result checker.
    initial
    begin
        heap_result_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with none expected: st %0d v %0d c %0d n %0d",
                             $time, status, out_vertex, out_cost, count);
                    failed = 1'b1;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (status !== exp_r.st)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, exp_r.st, status);
                        failed = 1'b1;
                    end
                    if (out_vertex !== exp_r.vtx)
                    begin
                        $display("%0t: out_vertex exp %0d got %0d",
                                 $time, exp_r.vtx, out_vertex);
                        failed = 1'b1;
                    end
                    if (out_cost !== exp_r.cst)
                    begin
                        $display("%0t: out_cost exp %0d got %0d",
                                 $time, exp_r.cst, out_cost);
                        failed = 1'b1;
                    end
                    if (count !== exp_r.cnt)
                    begin
                        $display("%0t: count exp %0d got %0d", $time, exp_r.cnt, count);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Output stall: a random wait per item, with some stretches of none.
    initial
    begin
        int wait_cycles;
        out_stall = 1'b0;
        forever
        begin
            wait_cycles = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    function automatic logic signed [COST_W-1:0] rand_cost();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed(32'($urandom_range(0, 40)) - 32'd20);
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic logic [VTX_W-1:0] rand_vertex();
        if (hot_vertex)
            return VTX_W'($urandom_range(0, 15));
        return VTX_W'($urandom());
    endfunction

    task automatic test_corner_cases();
        send_item(OP_EXTRACT, 10'd0, 32'sd0);
        send_item(OP_UPDATE, 10'd5, 32'sd1);
        send_item(OP_INSERT, 10'd1023, 32'sh7fff_ffff);
        send_item(OP_INSERT, 10'd0, 32'sh8000_0000);
        send_item(OP_INSERT, 10'd7, 32'sd5);
        send_item(OP_INSERT, 10'd8, 32'sd5);
        send_item(OP_INSERT, 10'd7, -32'sd3);
        send_item(OP_UPDATE, 10'd1023, -32'sd100);
        send_item(OP_UPDATE, 10'd8, 32'sd900);
        send_item(OP_UPDATE, 10'd0, 32'sh8000_0000);
        repeat (6) send_item(OP_EXTRACT, 10'd0, 32'sd0);
        send_item(OP_UPDATE, 10'd7, 32'sd1);
        send_item(OP_INSERT, 10'd3, 32'sd4);
        send_item(OP_EXTRACT, 10'd0, 32'sd0);
        send_item(OP_UPDATE, 10'd3, 32'sd4);
        send_item(OP_INSERT, 10'd9, 32'sd2);
        send_item(OP_CLEAR, 10'd0, 32'sd0);
        send_item(OP_UPDATE, 10'd9, 32'sd1);
    endtask

    // Fills the heap to capacity and checks the full response, then extracts 40 entries and clears it.
    task automatic test_full_heap();
        for (int k = 0; k < CAPACITY; k++)
            send_item(OP_INSERT, VTX_W'(k), rand_cost());
        send_item(OP_INSERT, 10'd1, 32'sd0);
        for (int k = 0; k < 40; k++)
            send_item(OP_EXTRACT, 10'd0, 32'sd0);
        send_item(OP_CLEAR, 10'd0, 32'sd0);
    endtask

    task automatic test_random_ops(int n_items);
        int pick;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 100 == 0)
                hot_vertex = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_item(OP_INSERT, rand_vertex(), rand_cost());
            else if (pick < 72)
                send_item(OP_EXTRACT, rand_vertex(), rand_cost());
            else if (pick < 98)
                send_item(OP_UPDATE, rand_vertex(), rand_cost());
            else
                send_item(OP_CLEAR, rand_vertex(), rand_cost());
        end
    endtask

    initial
    begin
        int guard;
        failed = 1'b0;
        hot_vertex = 1'b0;
        heap_size = 0;
        foreach (on_heap[k])
        begin
            on_heap[k] = 1'b0;
            pos_of[k] = 0;
        end
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = 2'd0;
        vertex = '0;
        cost = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_corner_cases();
        test_random_ops(150);
        test_full_heap();
        test_random_ops(150);
        in_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        if (!failed && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/imh_pkg.sv
rtl/imh_ctrl.sv
rtl/imh_dp.sv
rtl/indexed_min_heap.sv
dv/tb_indexed_min_heap.sv
